// ----- rtl/core/swmm_pkg.sv -----
package swmm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;
  localparam int AGE_W      = $clog2(WINDOW_MAX + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [AGE_W-1:0]           age_t;
  typedef logic [CFG_W-1:0]           cfg_t;

  typedef struct packed {
    logic    valid;
    age_t    age;
    sample_t value;
  } cell_t;

  // queue-level controls from the top
  typedef struct packed {
    logic clr;
    logic load;
    age_t ws;
  } queue_ctrl_t;

  // per-cell controls, shared by the whole row
  typedef struct packed {
    logic clr;
    logic load;
    logic shift;
    logic keep_smaller;
    age_t ws;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/swmm_cell.sv -----
module swmm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swmm_pkg::cell_ctrl_t ctrl,
  input  swmm_pkg::sample_t    sample,
  input  swmm_pkg::cell_t      right_i,
  input  logic                 prev_keep_i,
  output swmm_pkg::cell_t      cell_o,
  output logic                 keep_o,
  output swmm_pkg::sample_t    value_nxt_o
);
  import swmm_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;
  cell_t src;
  age_t  aged;
  logic  better;
  logic  keep;
  logic  place;

  always_comb begin
    // front expired: every cell takes its right neighbor's contents
    src    = ctrl.shift ? right_i : cell_r;
    aged   = src.age + AGE_W'(1);
    better = ctrl.keep_smaller ? (src.value < sample) : (src.value > sample);
    keep   = src.valid && (aged < ctrl.ws) && better;
    // new sample lands right after the last surviving cell
    place  = !keep && prev_keep_i;
    cell_nxt.valid = keep || place;
    cell_nxt.age   = keep ? aged : '0;
    cell_nxt.value = keep ? src.value : sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
      cell_r.age   <= '0;
    end else if (ctrl.clr) begin
      cell_r.valid <= 1'b0;
      cell_r.age   <= '0;
    end else if (ctrl.load) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o      = cell_r;
  assign keep_o      = keep;
  assign value_nxt_o = cell_nxt.value;

endmodule

// ----- rtl/core/swmm_queue.sv -----
module swmm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swmm_pkg::queue_ctrl_t qctrl,
  input  logic                  keep_smaller,
  input  swmm_pkg::sample_t     sample,
  output swmm_pkg::sample_t     front_nxt
);
  import swmm_pkg::*;

  cell_t                 cell_q [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] keep_q;
  logic [WINDOW_MAX-1:0] vld_vec;
  sample_t               value_nxt_q [WINDOW_MAX];
  cell_ctrl_t            ctrl;
  age_t                  front_aged;

  always_comb begin
    front_aged        = cell_q[0].age + AGE_W'(1);
    ctrl.clr          = qctrl.clr;
    ctrl.load         = qctrl.load;
    ctrl.ws           = qctrl.ws;
    ctrl.keep_smaller = keep_smaller;
    // only the oldest cell can run out of the window in one step
    ctrl.shift        = cell_q[0].valid && (front_aged >= qctrl.ws);
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_t right;
    logic  prev_keep;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_q[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_keep = keep_q[i-1];
    end

    swmm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (sample),
      .right_i     (right),
      .prev_keep_i (prev_keep),
      .cell_o      (cell_q[i]),
      .keep_o      (keep_q[i]),
      .value_nxt_o (value_nxt_q[i])
    );

    assign vld_vec[i] = cell_q[i].valid;
  end

  assign front_nxt = value_nxt_q[0];

  // live cells always form a packed run from the front
  a_vld_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("queue cells not packed to the front");

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    qctrl.clr |=> (vld_vec == '0))
    else $error("queue not empty after clear");

  a_load_front: assert property (@(posedge clk) disable iff (!rst_n)
    (qctrl.load && !qctrl.clr) |=> vld_vec[0])
    else $error("front cell empty after a push");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= int'(qctrl.ws))
    else $error("queue holds more cells than the window");

endmodule

// ----- rtl/core/sliding_window_min_max.sv -----
// Sliding window minimum / maximum over a stream of signed samples.
// Input channel: in_valid / in_stall with in_sample. Each accepted request
// produces exactly one result request on the output channel carrying the
// minimum and maximum of the last window_size samples (current one included)
// and out_window_full, which is set once window_size samples have arrived
// since reset or the last configuration write.
// The result is registered at the accepting edge. Throughput is one sample
// per cycle while in_stall is low; each sample updates a row of WINDOW_MAX
// compare cells per queue (min and max) in parallel.
// The output register holds the result while out_stall is high; in_stall
// follows out_stall while a result is pending, so no request is dropped.
// Reset (rst_n low, synchronous) empties both queues, clears the fill
// count and sets window_size to 1. Writing cfg_wr_data with cfg_wr_en also
// empties the window. Size 0 acts as 1; sizes above WINDOW_MAX saturate.
// Configure only while no request is in flight.
module sliding_window_min_max (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  swmm_pkg::cfg_t     cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  swmm_pkg::sample_t  in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output swmm_pkg::sample_t  out_window_min,
  output swmm_pkg::sample_t  out_window_max,
  output logic               out_window_full
);
  import swmm_pkg::*;

  age_t        ws_r;
  age_t        ws_nxt;
  age_t        fill_r;
  age_t        fill_nxt;
  logic        out_valid_r;
  sample_t     out_min_r;
  sample_t     out_max_r;
  logic        out_full_r;
  logic        accept;
  queue_ctrl_t qctrl;
  sample_t     min_front;
  sample_t     max_front;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (cfg_wr_data == '0) begin
      ws_nxt = AGE_W'(1);
    end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
      ws_nxt = AGE_W'(WINDOW_MAX);
    end else begin
      ws_nxt = AGE_W'(cfg_wr_data);
    end
    fill_nxt   = (fill_r == AGE_W'(WINDOW_MAX)) ? fill_r : fill_r + AGE_W'(1);
    qctrl.clr  = cfg_wr_en;
    qctrl.load = accept;
    qctrl.ws   = ws_r;
  end

  swmm_queue u_min_q (
    .clk          (clk),
    .rst_n        (rst_n),
    .qctrl        (qctrl),
    .keep_smaller (1'b1),
    .sample       (in_sample),
    .front_nxt    (min_front)
  );

  swmm_queue u_max_q (
    .clk          (clk),
    .rst_n        (rst_n),
    .qctrl        (qctrl),
    .keep_smaller (1'b0),
    .sample       (in_sample),
    .front_nxt    (max_front)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= AGE_W'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_wr_en) begin
      ws_r   <= ws_nxt;
      fill_r <= '0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !cfg_wr_en) begin
      out_min_r  <= min_front;
      out_max_r  <= max_front;
      out_full_r <= (fill_nxt >= ws_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_min  = out_min_r;
  assign out_window_max  = out_max_r;
  assign out_window_full = out_full_r;

  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_wr_en) |=> out_valid_r)
    else $error("accepted request produced no result");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_min_r <= out_max_r))
    else $error("window minimum above maximum");

  a_ws_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ws_r != '0) && (int'(ws_r) <= WINDOW_MAX))
    else $error("effective window size out of range");

endmodule
